// ===== src/hqct_pkg.sv =====
// Package for the hall quadrature counter / tachometer.
// Holds command codes, controller states, control/status structs and speed constants.
// No dependencies.
package hqct_pkg;

	localparam int CMD_W   = 2;
	localparam int POLE_W  = 7;
	localparam int CNT_W   = 32;
	localparam int SPEED_W = 29;
	localparam int EXT_W   = 32;
	localparam int PER_W   = 30;
	localparam int PROD_W  = POLE_W + PER_W;
	localparam int STEP_W  = 5;

	localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// 2000000 us/s times 256 (Q8)
	localparam logic [SPEED_W-1:0] SPEED_NUM    = 29'd512000000;
	// 20 rev/s in Q8
	localparam logic [SPEED_W-1:0] SPEED_MIN_Q8 = 29'd5120;
	localparam logic [POLE_W-1:0]  POLE_RESET   = 7'd1;
	localparam logic [STEP_W-1:0]  DIV_FIRST    = STEP_W'(SPEED_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic sel_en;
		logic mul_en;
		logic div_step;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic special;
		logic div_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== src/hqct_if.sv =====
// Valid/ready channel interfaces for the hall counter / tachometer.
// Depends on hqct_pkg for field widths.
interface hqct_in_if import hqct_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic             chan_a;
	logic             chan_b;
	logic [EXT_W-1:0] time_us;

	modport source (output valid, cmd, chan_a, chan_b, time_us, input ready);
	modport sink   (input valid, cmd, chan_a, chan_b, time_us, output ready);
endinterface

interface hqct_out_if import hqct_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [CNT_W-1:0]   position_count;
	logic                      direction_up;
	logic        [SPEED_W-1:0] speed_q8;

	modport source (output valid, position_count, direction_up, speed_q8, input ready);
	modport sink   (input valid, position_count, direction_up, speed_q8, output ready);
endinterface

// ===== src/hqct_ctrl.sv =====
// Controller FSM: sequences accept, period select, multiply, divide and result transfer.
// Depends on hqct_pkg.
module hqct_ctrl import hqct_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_cmd,
	input  dp_stat_t         stat,
	output logic             in_ready,
	output ctl_cmd_t         ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_d    = (in_cmd == CMD_QUERY) ? ST_SEL : ST_OUT;
				end
			end
			ST_SEL: begin
				ctl.sel_en = 1'b1;
				state_d    = stat.special ? ST_OUT : ST_MUL;
			end
			ST_MUL: begin
				ctl.mul_en = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/hqct_dp.sv =====
// Datapath: edge timestamps, half-period widths, position count, pole register,
// period multiply, restoring divider and the result register. Depends on hqct_pkg.
module hqct_dp import hqct_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [POLE_W-1:0]         cfg_wdata,
	input  ctl_cmd_t                  ctl,
	output dp_stat_t                  stat,
	input  logic [CMD_W-1:0]          in_cmd,
	input  logic                      in_chan_a,
	input  logic                      in_chan_b,
	input  logic [EXT_W-1:0]          in_time_us,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [CNT_W-1:0]   out_position_count,
	output logic                      out_direction_up,
	output logic        [SPEED_W-1:0] out_speed_q8
);

	localparam int WB = (TIME_BITS > PER_W) ? TIME_BITS : PER_W;

	logic [POLE_W-1:0]    pole_q;
	logic [TIME_BITS-1:0] rise_q, fall_q, wbr_q, wbf_q, rhw_q, rlw_q;
	logic                 level_q, dir_q;
	logic [CNT_W-1:0]     count_q;
	logic [SPEED_W-1:0]   speed_q;
	logic [PER_W-1:0]     period_q;
	logic [PROD_W-1:0]    div_q, rem_q;
	logic [SPEED_W-1:0]   quot_q;
	logic [STEP_W-1:0]    step_q;
	logic                 ovalid_q;
	logic signed [CNT_W-1:0] ocount_q;
	logic                 odir_q;
	logic [SPEED_W-1:0]   ospeed_q;

	logic [TIME_BITS-1:0] t_now;
	logic                 edge_dir;
	logic [TIME_BITS-1:0] sel_a, sel_b;
	logic [WB-1:0]        a_ext, b_ext, num_ext;
	logic [WB:0]          per_sum;
	logic                 sel_sat, sel_zero;
	logic [PROD_W:0]      rem_sh;
	logic                 rem_ge;
	logic [PROD_W:0]      rem_sub;
	logic [SPEED_W-1:0]   quot_n;

	assign t_now    = TIME_BITS'(in_time_us);
	assign edge_dir = (in_chan_a == in_chan_b);

	// period selection from the stored and running half-period widths
	always_comb begin
		priority if (rhw_q > wbr_q) begin
			sel_a = rhw_q;
			sel_b = wbf_q;
		end else if (rlw_q > wbf_q) begin
			sel_a = wbr_q;
			sel_b = rlw_q;
		end else begin
			sel_a = wbr_q;
			sel_b = wbf_q;
		end
		a_ext   = WB'(sel_a);
		b_ext   = WB'(sel_b);
		num_ext = WB'(SPEED_NUM);
		per_sum = (WB + 1)'(a_ext) + (WB + 1)'(b_ext);
		sel_sat  = 1'b0;
		sel_zero = 1'b0;
		priority if (pole_q == '0) begin
			sel_sat = 1'b1;
		end else if (a_ext > num_ext || b_ext > num_ext) begin
			sel_zero = 1'b1;
		end else if (per_sum == '0) begin
			sel_sat = 1'b1;
		end else if (per_sum > (WB + 1)'(SPEED_NUM)) begin
			sel_zero = 1'b1;
		end
	end

	// one restoring division step per cycle, dividend bits MSB first
	always_comb begin
		rem_sh  = {rem_q, SPEED_NUM[step_q]};
		rem_ge  = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
		quot_n  = {quot_q[SPEED_W-2:0], rem_ge};
	end

	assign stat.special  = sel_sat | sel_zero;
	assign stat.div_last = (step_q == '0);
	assign stat.out_free = !ovalid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q   <= POLE_RESET;
			rise_q   <= '0;
			fall_q   <= '0;
			wbr_q    <= '0;
			wbf_q    <= '0;
			rhw_q    <= '0;
			rlw_q    <= '0;
			level_q  <= 1'b0;
			dir_q    <= 1'b1;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pole_q <= cfg_wdata;
			end
			if (ctl.accept) begin
				unique case (in_cmd)
					CMD_EDGE: begin
						level_q <= in_chan_a;
						dir_q   <= edge_dir;
						if (in_chan_a) begin
							rise_q <= t_now;
						end else begin
							fall_q <= t_now;
						end
						count_q <= edge_dir ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
					end
					CMD_QUERY: begin
						if (level_q) begin
							wbr_q <= rise_q - fall_q;
							rhw_q <= t_now - rise_q;
						end else begin
							wbf_q <= fall_q - rise_q;
							rlw_q <= t_now - fall_q;
						end
					end
					CMD_CLEAR: begin
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (ctl.out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			speed_q <= '0;
		end
		if (ctl.sel_en) begin
			period_q <= per_sum[PER_W-1:0];
			speed_q  <= sel_sat ? SPEED_NUM : '0;
		end
		if (ctl.mul_en) begin
			div_q  <= PROD_W'(pole_q) * PROD_W'(period_q);
			rem_q  <= '0;
			quot_q <= '0;
			step_q <= DIV_FIRST;
		end
		if (ctl.div_step) begin
			rem_q  <= rem_ge ? rem_sub[PROD_W-1:0] : rem_sh[PROD_W-1:0];
			quot_q <= quot_n;
			step_q <= step_q - STEP_W'(1);
			if (stat.div_last) begin
				speed_q <= (quot_n < SPEED_MIN_Q8) ? '0 : quot_n;
			end
		end
		if (ctl.out_load) begin
			ocount_q <= count_q;
			odir_q   <= dir_q;
			ospeed_q <= speed_q;
		end
	end

	assign out_valid          = ovalid_q;
	assign out_position_count = ocount_q;
	assign out_direction_up   = odir_q;
	assign out_speed_q8       = ospeed_q;

endmodule

// ===== src/hall_quadrature_counter_tachometer.sv =====
// Top level of the hall quadrature counter / tachometer.
// Depends on hqct_pkg, hqct_if, hqct_ctrl and hqct_dp.
//
// Usage:
//   item   : valid/ready input channel; cmd 0 is a channel A edge, 1 a speed
//            query, 2 clears the position count, 3 does nothing.
//   result : valid/ready output channel, one transfer per input transfer, in
//            order, carrying count, direction and speed (Q8 rev/s, 0 unless query).
//   cfg_we / cfg_wdata : pole count register, to be written only while idle; the block does not enforce this.
// Sequencing: an edge, clear or unused command goes from the idle state
// straight to the output state; a query passes through period select and,
// unless the result is saturated or forced to 0, through the multiply state
// and the 29-step restoring divider (one quotient bit per cycle).
// One item is in work at a time; item.ready is high only in the idle state,
// so a new item is taken only after the last one is in the result register.
// The result register holds a finished item while the next one is taken in
// and processed; if the receiver stalls, that next item waits in the last
// state until the register frees up.
// Reset: count, widths and edge times clear, direction is forward, pole count 1.
module hall_quadrature_counter_tachometer import hqct_pkg::*; #(
	parameter int TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [POLE_W-1:0] cfg_wdata,
	hqct_in_if.sink           item,
	hqct_out_if.source        result
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	hqct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_cmd   (item.cmd),
		.stat     (stat),
		.in_ready (item.ready),
		.ctl      (ctl)
	);

	hqct_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.ctl                (ctl),
		.stat               (stat),
		.in_cmd             (item.cmd),
		.in_chan_a          (item.chan_a),
		.in_chan_b          (item.chan_b),
		.in_time_us         (item.time_us),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.out_position_count (result.position_count),
		.out_direction_up   (result.direction_up),
		.out_speed_q8       (result.speed_q8)
	);

endmodule
